// ----- hw/rtl/sorted_priority_queue_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue: assertion macros
// Compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH

// expr holds at every clock edge out of reset
`define SPQ_ASSERT_HOLD(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("spq: invariant violated");

// cons holds in the cycle after ante
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq: sequence violated");

`else

`define SPQ_ASSERT_HOLD(label, clk, rst_n, expr)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Sizes, codes and shared types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY   = 32;
    localparam int KEY_BITS   = 16;
    localparam int TAG_BITS   = 16;
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int COUNT_BITS = 6;   // width of the count port

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry entry;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert,
// left on remove.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_left_shift,
    input  spq_pkg::t_entry    i_left,
    input  spq_pkg::t_entry    i_right,
    output logic               o_shift,
    output spq_pkg::t_entry    o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // new entry lands here or further left: strict compare keeps FIFO on ties
    assign o_shift = !i_occupied || (i_ctl.entry.key < r_entry.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && o_shift) begin
            n_entry = i_left_shift ? i_left : i_ctl.entry;
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Shift-register priority queue: a chain of CAPACITY cells kept in ascending
// key order, one insert or remove of the smallest entry per transfer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | i_valid / o_ready   | i_func, i_key, i_item_tag
//  out     | output    | o_valid / i_ready   | o_status, o_out_key, o_out_tag,
//          |           |                     | o_count
//
//  In each operation all cells compare against the broadcast key and shift in
//  parallel, and the result goes to an output register.
//  One operation per cycle is sustained while the output is taken.
//  Reset clears the count and the output valid; cell contents are left as is.
//  A stalled output holds the result; o_ready stays high only while the
//  output register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_func,
    input  logic [spq_pkg::KEY_BITS-1:0] i_key,
    input  logic [spq_pkg::TAG_BITS-1:0] i_item_tag,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [spq_pkg::KEY_BITS-1:0] o_out_key,
    output logic [spq_pkg::TAG_BITS-1:0] o_out_tag,
    output logic [spq_pkg::COUNT_BITS-1:0] o_count
);

    localparam int CNT_W = spq_pkg::CNT_BITS;
    localparam int CAP   = spq_pkg::CAPACITY;

    // control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;

    // result register (payload, no reset)
    spq_pkg::t_status r_status;
    spq_pkg::t_entry  r_out;

    logic             in_xfer;
    logic             full;
    logic             empty;
    logic             ins_ok;
    logic             rem_ok;
    spq_pkg::t_cell_ctl ctl;

    // chain wiring
    spq_pkg::t_entry  w_entry [CAP];
    logic             w_shift [CAP];
    logic             w_occ   [CAP];

    logic [CNT_W+spq_pkg::COUNT_BITS-1:0] count_ext;

    assign o_ready = !r_out_valid || i_ready;
    assign in_xfer = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(CAP));
    assign empty   = (r_count == '0);
    assign ins_ok  = in_xfer && (spq_pkg::t_func'(i_func) == spq_pkg::FUNC_INSERT) && !full;
    assign rem_ok  = in_xfer && (spq_pkg::t_func'(i_func) == spq_pkg::FUNC_REMOVE) && !empty;

    assign ctl.ins       = ins_ok;
    assign ctl.rem       = rem_ok;
    assign ctl.entry.key = i_key;
    assign ctl.entry.tag = i_item_tag;

    always_comb begin
        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (rem_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // the cell chain; cell 0 holds the smallest key
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        spq_pkg::t_entry left_d;
        spq_pkg::t_entry right_d;
        logic            left_sh;

        assign w_occ[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign left_d  = ctl.entry;
            assign left_sh = 1'b0;
        end else begin : g_mid
            assign left_d  = w_entry[g-1];
            assign left_sh = w_shift[g-1];
        end

        if (g == CAP - 1) begin : g_tail
            assign right_d = '0;
        end else begin : g_body
            assign right_d = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (w_occ[g]),
            .i_left_shift (left_sh),
            .i_left       (left_d),
            .i_right      (right_d),
            .o_shift      (w_shift[g]),
            .o_entry      (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= rem_ok ? w_entry[0] : '0;
            if (spq_pkg::t_func'(i_func) == spq_pkg::FUNC_REMOVE) begin
                r_status <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
            end else begin
                r_status <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
            end
        end
    end

    // count reported after the operation, fitted to the port width
    assign count_ext = {{spq_pkg::COUNT_BITS{1'b0}}, r_count};

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_out_key = r_out.key;
    assign o_out_tag = r_out.tag;
    assign o_count   = count_ext[spq_pkg::COUNT_BITS-1:0];

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `SPQ_ASSERT_HOLD(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAP))
    `SPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, ins_ok, r_count == $past(r_count) + CNT_W'(1))
    `SPQ_ASSERT_HOLD(a_head_sorted, i_clk, i_rst_n, !(r_count >= CNT_W'(2)) || (w_entry[0].key <= w_entry[1].key))
    `SPQ_ASSERT_HOLD(a_empty_result, i_clk, i_rst_n, !(o_valid && o_status == spq_pkg::ST_EMPTY) || (r_count == '0 && o_out_key == '0))

endmodule

// ----- test/tb_top.sv -----
// ============================================================================
// tb_top: sorted priority queue testbench
// Drives insert and remove operations over the valid/ready input, checks every
// result transfer field by field against a shadow sorted store kept here, or
// a fixed row's values. Directed edge table, then fill/drain with random keys.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_OPS    = 1100;
    localparam int IDLE_PCT      = 12;
    localparam int STALL_AT      = 300;   // results taken before the long hold-off
    localparam int STALL_CYCLES  = 150;
    localparam int QUIET_FIRST   = 500;   // random ops sent with no idling
    localparam int QUIET_LAST    = 700;
    localparam int DRAIN_CYCLES  = 20;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        t_status               status;
        logic [KEY_BITS-1:0]   key;
        logic [TAG_BITS-1:0]   tag;
        logic [COUNT_BITS-1:0] count;
    } t_op_result;

    typedef struct {
        t_func               func;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
        bit                  fixed;   // expected result given in the row
        t_op_result          want;
    } t_op_row;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BOTH} t_mix;

    // DUT ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_func;
    logic [KEY_BITS-1:0]   i_key;
    logic [TAG_BITS-1:0]   i_item_tag;
    logic                  o_valid;
    logic                  i_ready;
    logic [1:0]            o_status;
    logic [KEY_BITS-1:0]   o_out_key;
    logic [TAG_BITS-1:0]   o_out_tag;
    logic [COUNT_BITS-1:0] o_count;

    // shadow of the sorted store
    logic [KEY_BITS-1:0] store_keys [CAPACITY];
    logic [TAG_BITS-1:0] store_tags [CAPACITY];
    int                  store_fill;

    t_op_result due_results[$];
    t_op_row    edge_rows[$];

    int  error_count;
    int  results_taken;
    int  hold_left;
    bit  hold_done;
    bit  quiet;
    int  stall_cycles;

    sorted_priority_queue DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_key      (i_key),
        .i_item_tag (i_item_tag),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_out_key  (o_out_key),
        .o_out_tag  (o_out_tag),
        .o_count    (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Apply one operation to the shadow store and return its result.
    // Insert scans from the back, so an equal key lands behind its peers.
    function automatic t_op_result sorted_store_op(t_func f, logic [KEY_BITS-1:0] k,
                                                   logic [TAG_BITS-1:0] t);
        t_op_result r;
        int         i;
        r.status = ST_OK;
        r.key    = '0;
        r.tag    = '0;
        if (f == FUNC_REMOVE) begin
            if (store_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.key = store_keys[0];
                r.tag = store_tags[0];
                for (i = 1; i < store_fill; i++) begin
                    store_keys[i-1] = store_keys[i];
                    store_tags[i-1] = store_tags[i];
                end
                store_fill--;
            end
        end else if (store_fill >= CAPACITY) begin
            r.status = ST_FULL;
        end else begin
            i = store_fill - 1;
            while (i >= 0 && k < store_keys[i]) begin
                store_keys[i+1] = store_keys[i];
                store_tags[i+1] = store_tags[i];
                i--;
            end
            store_keys[i+1] = k;
            store_tags[i+1] = t;
            store_fill++;
        end
        r.count = store_fill[COUNT_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (error_count < MAX_PRINTS)
            $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic add_row(t_func f, logic [KEY_BITS-1:0] k, logic [TAG_BITS-1:0] t,
                           bit fixed, t_status st, logic [KEY_BITS-1:0] wk,
                           logic [TAG_BITS-1:0] wt, int wc);
        t_op_row row;
        row.func        = f;
        row.key         = k;
        row.tag         = t;
        row.fixed       = fixed;
        row.want.status = st;
        row.want.key    = wk;
        row.want.tag    = wt;
        row.want.count  = wc[COUNT_BITS-1:0];
        edge_rows.push_back(row);
    endtask

    // Offer one operation on the input channel and hold it until transferred.
    // Called at a rising edge; leaves at the edge of the transfer.
    task automatic send_op(t_op_row row);
        t_op_result r;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= row.func;
        i_key      <= row.key;
        i_item_tag <= row.tag;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = sorted_store_op(row.func, row.key, row.tag);
        due_results.push_back(row.fixed ? row.want : r);
    endtask

    // Receiver: take results, random stalls, one long hold-off so the
    // output register stays full and the input channel backs up.
    always @(posedge i_clk) begin
        t_op_result w;
        if (i_rst_n && o_valid && i_ready) begin
            results_taken++;
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing expected, status",
                                longint'(o_status), longint'(0));
            end else begin
                w = due_results.pop_front();
                if (o_status != w.status)
                    report_mismatch("status", longint'(o_status), longint'(w.status));
                if (o_out_key != w.key)
                    report_mismatch("out_key", longint'(o_out_key), longint'(w.key));
                if (o_out_tag != w.tag)
                    report_mismatch("out_tag", longint'(o_out_tag), longint'(w.tag));
                if (o_count != w.count)
                    report_mismatch("count", longint'(o_count), longint'(w.count));
            end
        end
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && results_taken >= STALL_AT) begin
            hold_done = 1'b1;
            hold_left = STALL_CYCLES - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: cycles without a transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_MAX) begin
                $display("watchdog: no transfer in %0d cycles", WATCHDOG_MAX);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_op_row row;
        t_mix    mix;
        int      sel;
        int      n;

        error_count   = 0;
        results_taken = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        stall_cycles  = 0;
        store_fill    = 0;
        quiet         = 1'b0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_func     <= FUNC_INSERT;
        i_key      <= '0;
        i_item_tag <= '0;
        i_ready    <= 1'b0;

        // edge table: empty remove, extreme keys and tags, equal keys
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 1, ST_EMPTY, 16'h0000, 16'h0000, 0);
        add_row(FUNC_INSERT, 16'hFFFF, 16'hFFFF, 1, ST_OK,    16'h0000, 16'h0000, 1);
        add_row(FUNC_INSERT, 16'h0000, 16'h0000, 1, ST_OK,    16'h0000, 16'h0000, 2);
        add_row(FUNC_INSERT, 16'h8000, 16'h5555, 1, ST_OK,    16'h0000, 16'h0000, 3);
        add_row(FUNC_REMOVE, 16'hFFFF, 16'hFFFF, 1, ST_OK,    16'h0000, 16'h0000, 2);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 1, ST_OK,    16'h8000, 16'h5555, 1);
        add_row(FUNC_INSERT, 16'h1234, 16'hAAAA, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_INSERT, 16'h1234, 16'h0001, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_INSERT, 16'h1234, 16'h0002, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_INSERT, 16'h0FFF, 16'h7FFF, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 1, ST_OK,    16'hFFFF, 16'hFFFF, 0);
        add_row(FUNC_REMOVE, 16'hFFFF, 16'hFFFF, 1, ST_EMPTY, 16'h0000, 16'h0000, 0);
        add_row(FUNC_INSERT, 16'hFFFF, 16'h0000, 1, ST_OK,    16'h0000, 16'h0000, 1);
        add_row(FUNC_INSERT, 16'h0000, 16'hFFFF, 1, ST_OK,    16'h0000, 16'h0000, 2);
        add_row(FUNC_INSERT, 16'hFFFF, 16'h1234, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 0, ST_OK,    16'h0000, 16'h0000, 0);
        add_row(FUNC_REMOVE, 16'h0000, 16'h0000, 1, ST_EMPTY, 16'h0000, 16'h0000, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (edge_rows[i]) send_op(edge_rows[i]);

        // Random sweeps: fill to full (and knock on it), drain to empty
        // (and knock on that), with mixed stretches in between.
        mix = MIX_FILL;
        for (n = 0; n < RANDOM_OPS; n++) begin
            quiet <= (n >= QUIET_FIRST && n < QUIET_LAST);
            case (mix)
                MIX_FILL: begin
                    if (store_fill == CAPACITY && $urandom_range(0, 3) == 0)
                        mix = MIX_DRAIN;
                end
                MIX_DRAIN: begin
                    if (store_fill == 0 && $urandom_range(0, 3) == 0)
                        mix = $urandom_range(0, 1) ? MIX_FILL : MIX_BOTH;
                end
                default: begin
                    if ($urandom_range(0, 49) == 0) mix = MIX_FILL;
                end
            endcase
            sel = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:  row.func = (sel < 85) ? FUNC_INSERT : FUNC_REMOVE;
                MIX_DRAIN: row.func = (sel < 15) ? FUNC_INSERT : FUNC_REMOVE;
                default:   row.func = (sel < 50) ? FUNC_INSERT : FUNC_REMOVE;
            endcase
            // wide keys, a narrow band for ties, and the extremes
            sel = $urandom_range(0, 99);
            if (sel < 50)
                row.key = KEY_BITS'($urandom_range(0, 65535));
            else if (sel < 80)
                row.key = KEY_BITS'($urandom_range(0, 7));
            else if (sel < 90)
                row.key = 16'hFFFF;
            else
                row.key = 16'h0000;
            row.tag   = TAG_BITS'($urandom_range(0, 65535));
            row.fixed = 1'b0;
            send_op(row);
        end
        i_valid <= 1'b0;
        quiet   <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
